// ----- hw/rtl/md5_pkg.sv -----
package md5_pkg;

	// MD5 initial chaining values A, B, C, D.
	localparam logic [31:0] INIT_WORDS [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	// Per-step additive constants.
	localparam logic [31:0] K_TAB [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// Rotate amounts per round and per step within a group of four.
	localparam logic [4:0] SHIFT_TAB [4][4] = '{
		'{5'd7, 5'd12, 5'd17, 5'd22},
		'{5'd5, 5'd9,  5'd14, 5'd20},
		'{5'd4, 5'd11, 5'd16, 5'd23},
		'{5'd6, 5'd10, 5'd15, 5'd21}
	};

	// Message word index = (start + stride * step) mod 16, per round.
	localparam logic [3:0] G_START  [4] = '{4'd0, 4'd1, 4'd5, 4'd0};
	localparam logic [3:0] G_STRIDE [4] = '{4'd1, 4'd5, 4'd3, 4'd7};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_PAD2,
		ST_EMIT
	} md5_state_t;

	// What follows a compression pass.
	typedef enum logic [1:0] {
		KD_DATA,
		KD_DATA_LAST,
		KD_OVF,
		KD_FINAL
	} md5_kind_t;

	typedef struct packed {
		logic byte_wr;
		logic pad;
		logic pad2;
		logic load;
		logic round;
		logic fold;
		logic emit;
	} md5_cmd_t;

	typedef struct packed {
		logic pos_wrap;
		logic pos_hi;
		logic step_last;
	} md5_status_t;

	function automatic logic [3:0] msg_index(input logic [5:0] step);
		logic [1:0] rnd;
		logic [7:0] prod;
		rnd  = step[5:4];
		prod = {4'b0000, step[3:0]} * {4'b0000, G_STRIDE[rnd]} + {4'b0000, G_START[rnd]};
		return prod[3:0];
	endfunction

endpackage

// ----- hw/rtl/md5_ctrl.sv -----
module md5_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_has_byte,
	input  logic                in_last,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  md5_pkg::md5_status_t st,
	output md5_pkg::md5_cmd_t   cmd
);
	import md5_pkg::*;

	md5_state_t state_q, state_d;
	md5_kind_t  kind_q, kind_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KD_DATA;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		kind_d   = kind_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.byte_wr = in_has_byte;
					if (in_has_byte && st.pos_wrap) begin
						kind_d  = in_last ? KD_DATA_LAST : KD_DATA;
						state_d = ST_LOAD;
					end else if (in_last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (st.step_last) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				unique case (kind_q)
					KD_DATA:      state_d = ST_IDLE;
					KD_DATA_LAST: state_d = ST_PAD;
					KD_OVF:       state_d = ST_PAD2;
					KD_FINAL:     state_d = ST_EMIT;
					default:      state_d = ST_IDLE;
				endcase
			end
			ST_PAD: begin
				cmd.pad = 1'b1;
				kind_d  = st.pos_hi ? KD_OVF : KD_FINAL;
				state_d = ST_LOAD;
			end
			ST_PAD2: begin
				cmd.pad2 = 1'b1;
				kind_d   = KD_FINAL;
				state_d  = ST_LOAD;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/md5_dp.sv -----
module md5_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           data_byte,
	input  md5_pkg::md5_cmd_t    cmd,
	output md5_pkg::md5_status_t st,
	output logic [127:0]         digest
);
	import md5_pkg::*;

	logic [31:0]  chain_q [4];
	logic [31:0]  buf_q [16];
	logic [5:0]   pos_q;
	logic [60:0]  cnt_q;
	logic [5:0]   step_q;
	logic [31:0]  a_q, b_q, c_q, d_q, pre_q;
	logic [127:0] out_q;

	logic [1:0]  rnd;
	logic [31:0] f, sum, rot, tmp;
	logic [63:0] dbl, len_bits;
	logic [5:0]  step_nx;
	logic [31:0] pre_nx;

	assign st.pos_wrap  = (pos_q == 6'd63);
	assign st.pos_hi    = (pos_q >= LEN_POS);
	assign st.step_last = (step_q == 6'd63);
	assign digest       = out_q;
	assign len_bits     = {cnt_q, 3'b000};

	always_comb begin
		rnd = step_q[5:4];
		case (rnd)
			2'd0:    f = (b_q & c_q) | (~b_q & d_q);
			2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
			2'd2:    f = b_q ^ c_q ^ d_q;
			default: f = c_q ^ (b_q | ~d_q);
		endcase
		sum     = pre_q + f;
		dbl     = {sum, sum} << SHIFT_TAB[rnd][step_q[1:0]];
		rot     = dbl[63:32];
		tmp     = b_q + rot;
		step_nx = step_q + 6'd1;
		// The next step's a is the current d, so its sum is started now.
		pre_nx  = d_q + K_TAB[step_nx] + buf_q[msg_index(step_nx)];
	end

	// Chaining words, byte position and length counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				chain_q[i] <= INIT_WORDS[i];
			end
			pos_q  <= '0;
			cnt_q  <= '0;
			step_q <= '0;
		end else begin
			if (cmd.byte_wr) begin
				pos_q <= pos_q + 6'd1;
				cnt_q <= cnt_q + 61'd1;
			end
			if (cmd.load) begin
				step_q <= '0;
			end else if (cmd.round) begin
				step_q <= step_nx;
			end
			if (cmd.fold) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
			end else if (cmd.emit) begin
				for (int i = 0; i < 4; i++) begin
					chain_q[i] <= INIT_WORDS[i];
				end
				pos_q <= '0;
				cnt_q <= '0;
			end
		end
	end

	// Working variables and the digest register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= chain_q[0];
			b_q   <= chain_q[1];
			c_q   <= chain_q[2];
			d_q   <= chain_q[3];
			pre_q <= chain_q[0] + K_TAB[0] + buf_q[0];
		end else if (cmd.round) begin
			a_q   <= d_q;
			b_q   <= tmp;
			c_q   <= b_q;
			d_q   <= c_q;
			pre_q <= pre_nx;
		end
		if (cmd.emit) begin
			out_q <= {chain_q[3], chain_q[2], chain_q[1], chain_q[0]};
		end
	end

	// Block buffer: byte writes, the padding pass and the overflow pass.
	always_ff @(posedge clk) begin
		if (cmd.byte_wr) begin
			buf_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= data_byte;
		end else if (cmd.pad) begin
			for (int w = 0; w < 16; w++) begin
				// The length words go in directly when the pad byte leaves room.
				if (w >= 14 && !st.pos_hi) begin
					buf_q[w] <= len_bits[(w - 14) * 32 +: 32];
				end else begin
					for (int l = 0; l < 4; l++) begin
						if (6'(w * 4 + l) == pos_q) begin
							buf_q[w][l*8 +: 8] <= PAD_BYTE;
						end else if (6'(w * 4 + l) > pos_q) begin
							buf_q[w][l*8 +: 8] <= 8'h00;
						end
					end
				end
			end
		end else if (cmd.pad2) begin
			for (int w = 0; w < 14; w++) begin
				buf_q[w] <= '0;
			end
			buf_q[14] <= len_bits[31:0];
			buf_q[15] <= len_bits[63:32];
		end
	end

endmodule

// ----- hw/rtl/md5_hash_engine_top.sv -----
// Channel   | Direction | Signals                                   | Contents
// ----------+-----------+-------------------------------------------+---------------------------
// s_axis    | input     | tvalid, tready, tdata[7:0], tuser, tlast  | message byte, byte flag, end
// m_axis    | output    | tvalid, tready, tdata[127:0]              | 128-bit digest
//
// A transaction carrying a byte that does not complete a 64-byte block is taken while the
// engine is idle. The byte that completes a block adds a compression pass (load, 64 round
// steps, fold) in the single shared round unit. A final transaction adds a padding step, a
// pass and an output step, with a second padding step and pass when the padding overflows.
// Reset (arst_n low) restores the MD5 initial chaining values and clears the counters.
// A waiting digest does not block new input; only a second digest stalls until it is taken.

module md5_hash_engine_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	input  logic         s_axis_tuser,  // [0] has_byte
	input  logic         s_axis_tlast,  // is_last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // [63:0] digest_first_half, [127:64] digest_second_half
);
	import md5_pkg::*;

	md5_cmd_t    cmd;
	md5_status_t st;

	// The controller sequences byte intake, compression passes, padding and output.
	md5_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_has_byte(s_axis_tuser),
		.in_last    (s_axis_tlast),
		.in_ready   (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.st         (st),
		.cmd        (cmd)
	);

	// The datapath holds the block buffer, chaining words, the round unit and the
	// digest register that parts the output from the rest of the engine.
	md5_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_byte(s_axis_tdata),
		.cmd      (cmd),
		.st       (st),
		.digest   (m_axis_tdata)
	);

endmodule

// ----- verif/md5_hash_engine_top_test.sv -----
module md5_hash_engine_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	// Chaining values that every message starts from.
	localparam logic [31:0] CHAIN_START [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	// Additive constant of each of the 64 steps.
	localparam logic [31:0] STEP_ADD [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// Left-rotate amounts, one row per round, indexed by step modulo four.
	localparam int ROTATE_BY [4][4] = '{
		'{7, 12, 17, 22},
		'{5, 9, 14, 20},
		'{4, 11, 16, 23},
		'{6, 10, 15, 21}
	};

	// The message word used by a step is (first + stride * step) modulo 16.
	localparam int WORD_FIRST  [4] = '{0, 1, 5, 0};
	localparam int WORD_STRIDE [4] = '{1, 5, 3, 7};

	localparam logic [7:0] MSG_PAD     = 8'h80;
	localparam int         LENGTH_LANE = 56;

	// Message lengths that put the pad byte right around the length field and
	// the block boundary, where the extra padding block appears or vanishes.
	localparam int EDGE_LENGTHS [7] = '{55, 56, 57, 63, 64, 65, 120};

	// The scoreboard carries its own copy of the hashing state. Every accepted
	// input transaction is absorbed into it, and a closing transaction pushes
	// the digest that the block must return next.
	class md5_digest_board;
		logic [31:0]  chain [4];
		logic [31:0]  block_words [16];
		logic [5:0]   lane;
		logic [60:0]  done_bytes;
		logic [127:0] expected_digests [$];
		int           errors = 0;

		function new();
			restart();
		endfunction

		function void restart();
			chain      = CHAIN_START;
			lane       = '0;
			done_bytes = '0;
		endfunction

		function void put_lane(int pos, logic [7:0] value);
			block_words[pos / 4][(pos % 4) * 8 +: 8] = value;
		endfunction

		function void compress();
			logic [31:0] a, b, c, d, f, sum;
			int          step, rnd, idx, rot;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			for (step = 0; step < 64; step++) begin
				rnd = step / 16;
				idx = step % 16;
				case (rnd)
					0: f = (b & c) | (~b & d);
					1: f = (b & d) | (c & ~d);
					2: f = b ^ c ^ d;
					default: f = c ^ (b | ~d);
				endcase
				sum = a + f + STEP_ADD[step]
					+ block_words[(WORD_FIRST[rnd] + WORD_STRIDE[rnd] * idx) % 16];
				rot = ROTATE_BY[rnd][idx % 4];
				a = d;
				d = c;
				c = b;
				b = b + ((sum << rot) | (sum >> (32 - rot)));
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
		endfunction

		// Notes one accepted input transaction.
		function void take_item(logic [7:0] value, logic has, logic last);
			logic [60:0] total;
			int          p;
			if (has) begin
				put_lane(lane, value);
				lane++;
				if (lane == 0) begin
					compress();
					done_bytes += 61'd64;
				end
			end
			if (!last)
				return;
			total = done_bytes + 61'(lane);
			put_lane(lane, MSG_PAD);
			for (p = int'(lane) + 1; p < 64; p++)
				put_lane(p, 8'h00);
			if (lane >= LENGTH_LANE) begin
				compress();
				for (p = 0; p < LENGTH_LANE; p++)
					put_lane(p, 8'h00);
			end
			{block_words[15], block_words[14]} = {total, 3'b000};
			compress();
			expected_digests.push_back({chain[3], chain[2], chain[1], chain[0]});
			restart();
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] digest error: %s", $time, what);
		endtask

		// Checks one accepted output transaction against the oldest digest.
		task check_digest(logic [127:0] got);
			logic [127:0] want;
			if (expected_digests.size() == 0) begin
				report($sformatf("digest %h arrived with none pending", got));
				return;
			end
			want = expected_digests.pop_front();
			if (got[63:0] !== want[63:0])
				report($sformatf("first half %h, expected %h", got[63:0], want[63:0]));
			if (got[127:64] !== want[127:64])
				report($sformatf("second half %h, expected %h", got[127:64], want[127:64]));
		endtask
	endclass

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata  = '0;   // [7:0] data_byte
	logic         s_axis_tuser  = 1'b0; // [0] has_byte
	logic         s_axis_tlast  = 1'b0; // is_last
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;         // [63:0] digest_first_half, [127:64] digest_second_half

	md5_digest_board digests = new();
	int              items_fed = 0;
	int              src_burst = 0;

	md5_hash_engine_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5ns clk = ~clk;

	// Draws the idle cycles before the next transaction of one side. Now and
	// then a side enters a run of back-to-back transactions with no idling.
	function automatic int pick_gap(ref int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			burst = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 7);
	endfunction

	// Offers one input transaction and waits for the block to take it. The
	// task is entered and left at a falling edge. With no idle cycles drawn
	// tvalid simply stays high, so it is never lowered and raised in one step.
	task automatic send_item(input logic [7:0] value, input logic has, input logic last);
		int gap;
		gap = pick_gap(src_burst);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= has;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		digests.take_item(value, has, last);
		if (has || last)
			items_fed++;
		@(negedge clk);
	endtask

	// Sends a whole message of random bytes. It is closed either by its last
	// byte or by a trailing empty final transaction; now and then an idle
	// transaction, which the block must ignore, is slipped in between bytes.
	task automatic send_message(input int len);
		bit close_on_byte;
		int i;
		close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
		end
		if (!close_on_byte)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin : byte_source
		int pick, len;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The empty message: a single empty final transaction right after reset.
		send_item(8'hff, 1'b0, 1'b1);
		// "abc" with two idle transactions inside, closed by the byte itself.
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// Single-byte messages at both extremes of the byte value.
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		// A message closed by an empty final transaction after its bytes.
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7f, 1'b1, 1'b0);
		send_item(8'h01, 1'b0, 1'b1);
		// Two empty messages in a row check the restart after a digest.
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h55, 1'b0, 1'b1);

		// Random messages: mostly short, some long enough to cross blocks and
		// to land the pad byte next to the length field.
		items_fed = 0;
		while (items_fed < 550) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				len = $urandom_range(0, 6);
			else if (pick < 9)
				len = EDGE_LENGTHS[$urandom_range(0, 6)];
			else
				len = $urandom_range(7, 40);
			send_message(len);
		end
		s_axis_tvalid <= 1'b0;

		// Let the last digests drain, then give the block time to show any
		// stray output before the verdict.
		while (digests.expected_digests.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
		if (digests.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Takes digests with random idle cycles. Once, after a few digests, the
	// receiver holds off for a long stretch while messages keep coming, so a
	// second digest backs up behind the first and the input side stalls.
	initial begin : digest_sink
		int gap, sink_burst, taken;
		sink_burst = 0;
		taken      = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (taken == 6)
				gap = 3000;
			else
				gap = pick_gap(sink_burst);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			digests.check_digest(m_axis_tdata);
			taken++;
			@(negedge clk);
		end
	end

	// A run that hangs anywhere ends here.
	initial begin : watchdog
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule
